FILE: rtl/quaternion_to_euler_recentred_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef QUATERNION_TO_EULER_RECENTRED_MACROS_SVH
`define QUATERNION_TO_EULER_RECENTRED_MACROS_SVH
`ifndef SYNTH
`define Q2E_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define Q2E_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define Q2E_ASSERT_IMP(label, clk, rst_n, a, c)
`define Q2E_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/q2e_pkg.sv
`timescale 1ns / 1ps
package q2e_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int COR_N        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int ISQRT_STEPS  = 29;
    localparam int MUL_COUNT    = 9;

    localparam int XW = 40;
    localparam int ZW = 27;
    localparam int SW = 34;

    localparam logic signed [15:0] DEG180_Q7 = 16'sd23040;
    localparam logic signed [16:0] DEG360_Q7 = 17'sd46080;
    localparam logic signed [15:0] DEG90_Q7  = 16'sd11520;
    localparam logic signed [ZW-1:0] DEG180_INT = 27'sd11796480;

    localparam logic [1:0] SEL_YAW   = 2'd0;
    localparam logic [1:0] SEL_PITCH = 2'd1;
    localparam logic [1:0] SEL_ROLL  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [3:0] mul_idx;
        logic       sq_en;
        logic       sqrt_step;
        logic       cor_init;
        logic       cor_step;
        logic [4:0] cor_idx;
        logic       ang_store;
        logic [1:0] sel;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic p_sat;
    } t_sts;

    function automatic logic [21:0] atan_lut(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage

FILE: rtl/quaternion_to_euler_recentred.sv
// Each beat runs the products, the 29-step square root and three CORDIC runs of 16 steps on one
// shared unit; when pitch saturates, the square root and the pitch run are skipped.
// One beat is processed at a time, and the next input is taken while a result waits.
// Reset is synchronous and active low; it clears the controller, the output valid and the
// centring offsets, so the first beat after reset sets the offsets and returns all zero.
`timescale 1ns / 1ps
`include "quaternion_to_euler_recentred_macros.svh"
module quaternion_to_euler_recentred (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // yaw_deg, pitch_deg, roll_deg
);
    q2e_pkg::t_cmd cmd;
    q2e_pkg::t_sts sts;
    logic signed [15:0] yaw_out;
    logic signed [15:0] roll_out;
    logic               yaw_ok;
    logic               roll_ok;

    q2e_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    q2e_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_quat   (i_s_tdata),
        .o_result (o_m_tdata)
    );

    assign yaw_out  = o_m_tdata[15:0];
    assign roll_out = o_m_tdata[47:32];
    assign yaw_ok   = (yaw_out <= q2e_pkg::DEG180_Q7) && (yaw_out >= -q2e_pkg::DEG180_Q7);
    assign roll_ok  = (roll_out <= q2e_pkg::DEG180_Q7) && (roll_out >= -q2e_pkg::DEG180_Q7);

    `Q2E_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `Q2E_ASSERT_IMP(a_yaw_range, i_clk, i_rst_n, o_m_tvalid, yaw_ok)
    `Q2E_ASSERT_IMP(a_roll_range, i_clk, i_rst_n, o_m_tvalid, roll_ok)
endmodule

FILE: rtl/q2e_dp.sv
`timescale 1ns / 1ps
module q2e_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  q2e_pkg::t_cmd     i_cmd,
    output q2e_pkg::t_sts     o_sts,
    input  logic [63:0]       i_quat,
    output logic [47:0]       o_result
);
    localparam int XW = q2e_pkg::XW;
    localparam int ZW = q2e_pkg::ZW;
    localparam int SW = q2e_pkg::SW;

    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [15:0] ma, mb;
    logic signed [31:0] r_prod;
    logic [3:0]         r_pidx;
    logic               r_pv;
    logic signed [SW-1:0] r_ssr, r_scr, r_ssp, r_ssy, r_scy;
    logic signed [SW-1:0] pe;

    logic signed [SW:0] sp;
    logic [27:0]        mag;
    logic [55:0]        mag_sq;
    logic [56:0]        r_n, r_root, r_bit;
    logic [57:0]        trial;
    logic               r_sq_d;

    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic                 r_zero;
    logic signed [XW-1:0] ix, iy, dx, dy;
    logic signed [ZW-1:0] at, zf;
    logic signed [17:0]   q18;
    logic signed [15:0]   qang;

    logic signed [15:0] r_ang [3];
    logic signed [15:0] r_off [3];
    logic               r_centred;
    logic signed [15:0] r_out [3];
    logic signed [15:0] offv  [3];
    logic signed [16:0] diff  [3];
    logic signed [15:0] wrapd [3];

    always_comb begin
        case (i_cmd.mul_idx)
            4'd0:    begin ma = r_qw; mb = r_qx; end
            4'd1:    begin ma = r_qy; mb = r_qz; end
            4'd2:    begin ma = r_qx; mb = r_qx; end
            4'd3:    begin ma = r_qy; mb = r_qy; end
            4'd4:    begin ma = r_qw; mb = r_qy; end
            4'd5:    begin ma = r_qz; mb = r_qx; end
            4'd6:    begin ma = r_qw; mb = r_qz; end
            4'd7:    begin ma = r_qx; mb = r_qy; end
            default: begin ma = r_qz; mb = r_qz; end
        endcase
    end

    assign pe     = SW'(r_prod);
    assign sp     = {r_ssp, 1'b0};
    assign o_sts.p_sat = (sp >= (SW+1)'(64'sd268435456)) || (sp <= -(SW+1)'(64'sd268435456));
    assign mag    = sp[SW] ? 28'(-sp) : 28'(sp);
    assign trial  = {1'b0, r_root} + {1'b0, r_bit};

    always_comb begin
        case (i_cmd.sel)
            q2e_pkg::SEL_PITCH: begin
                iy = XW'(sp);
                ix = XW'({1'b0, r_root});
            end
            q2e_pkg::SEL_YAW: begin
                iy = XW'($signed({r_ssy, 1'b0}));
                ix = XW'(64'sd268435456) - XW'({r_scy, 1'b0});
            end
            default: begin
                iy = XW'($signed({r_ssr, 1'b0}));
                ix = XW'(64'sd268435456) - XW'({r_scr, 1'b0});
            end
        endcase
    end

    assign dx = r_cy >>> i_cmd.cor_idx;
    assign dy = r_cx >>> i_cmd.cor_idx;
    assign at = ZW'({1'b0, q2e_pkg::atan_lut(i_cmd.cor_idx)});
    assign zf = r_zero ? '0 : r_cz;
    assign q18 = 18'((zf + ZW'(256)) >>> 9);
    assign qang = (q18 > 18'(q2e_pkg::DEG180_Q7)) ? q2e_pkg::DEG180_Q7 :
                  (q18 < -18'(q2e_pkg::DEG180_Q7)) ? -q2e_pkg::DEG180_Q7 : 16'(q18);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            offv[k] = r_centred ? r_off[k] : r_ang[k];
            diff[k] = 17'(r_ang[k]) - 17'(offv[k]);
            if (diff[k] < -17'(q2e_pkg::DEG180_Q7)) begin
                wrapd[k] = 16'(diff[k] + q2e_pkg::DEG360_Q7);
            end else if (diff[k] > 17'(q2e_pkg::DEG180_Q7)) begin
                wrapd[k] = 16'(diff[k] - q2e_pkg::DEG360_Q7);
            end else begin
                wrapd[k] = 16'(diff[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= 1'b0;
            r_sq_d    <= 1'b0;
            r_centred <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_off[k] <= '0;
            end
        end else begin
            r_pv   <= i_cmd.mul_en;
            r_sq_d <= i_cmd.sq_en;
            if (i_cmd.fin && !r_centred) begin
                r_centred <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_off[k] <= r_ang[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qw  <= i_quat[15:0];
            r_qx  <= i_quat[31:16];
            r_qy  <= i_quat[47:32];
            r_qz  <= i_quat[63:48];
            r_ssr <= '0;
            r_scr <= '0;
            r_ssp <= '0;
            r_ssy <= '0;
            r_scy <= '0;
        end
        r_prod <= ma * mb;
        r_pidx <= i_cmd.mul_idx;
        if (r_pv) begin
            case (r_pidx)
                4'd0, 4'd1: r_ssr <= r_ssr + pe;
                4'd2:       r_scr <= r_scr + pe;
                4'd3: begin
                    r_scr <= r_scr + pe;
                    r_scy <= r_scy + pe;
                end
                4'd4:       r_ssp <= r_ssp + pe;
                4'd5:       r_ssp <= r_ssp - pe;
                4'd6, 4'd7: r_ssy <= r_ssy + pe;
                default:    r_scy <= r_scy + pe;
            endcase
        end
        if (i_cmd.sq_en) begin
            mag_sq <= mag * mag;
            r_root <= '0;
            r_bit  <= 57'(1) << 56;
        end
        if (r_sq_d) begin
            r_n <= (57'(1) << 56) - 57'(mag_sq);
        end
        if (i_cmd.sqrt_step) begin
            if ({1'b0, r_n} >= trial) begin
                r_n    <= 57'({1'b0, r_n} - trial);
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.cor_init) begin
            r_zero <= (ix == '0) && (iy == '0);
            if (ix < 0) begin
                r_cx <= -ix;
                r_cy <= -iy;
                r_cz <= (iy >= 0) ? q2e_pkg::DEG180_INT : -q2e_pkg::DEG180_INT;
            end else begin
                r_cx <= ix;
                r_cy <= iy;
                r_cz <= '0;
            end
        end
        if (i_cmd.cor_step) begin
            if (r_cy >= 0) begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + at;
            end else begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - at;
            end
        end
        if (i_cmd.sq_en && o_sts.p_sat) begin
            r_ang[q2e_pkg::SEL_PITCH] <= sp[SW] ? -q2e_pkg::DEG90_Q7 : q2e_pkg::DEG90_Q7;
        end
        if (i_cmd.ang_store) begin
            r_ang[i_cmd.sel] <= qang;
        end
        if (i_cmd.fin) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= wrapd[k];
            end
        end
    end

    assign o_result = {r_out[2], r_out[1], r_out[0]};
endmodule

FILE: rtl/q2e_ctrl.sv
`timescale 1ns / 1ps
module q2e_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output q2e_pkg::t_cmd o_cmd,
    input  q2e_pkg::t_sts i_sts
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_SQ     = 9'b000000100,
        S_SQW    = 9'b000001000,
        S_SQRT   = 9'b000010000,
        S_CINIT  = 9'b000100000,
        S_CSTEP  = 9'b001000000,
        S_CSTORE = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_sel, n_sel;
    logic       r_ovalid, n_ovalid;
    logic       r_sat, n_sat;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sel    = r_sel;
        n_sat    = r_sat;
        n_ovalid = r_ovalid && !i_m_tready;
        o_cmd    = '0;
        o_cmd.mul_idx = r_cnt[3:0];
        o_cmd.cor_idx = r_cnt;
        o_cmd.sel     = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = (r_cnt < 5'(q2e_pkg::MUL_COUNT));
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(q2e_pkg::MUL_COUNT)) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_en = 1'b1;
                n_sat = i_sts.p_sat;
                n_state = S_SQW;
            end
            S_SQW: begin
                n_cnt = '0;
                if (r_sat) begin
                    n_sel   = q2e_pkg::SEL_YAW;
                    n_state = S_CINIT;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(q2e_pkg::ISQRT_STEPS - 1)) begin
                    n_sel   = q2e_pkg::SEL_PITCH;
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.cor_init = 1'b1;
                n_cnt   = '0;
                n_state = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.cor_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(q2e_pkg::COR_N - 1)) begin
                    n_state = S_CSTORE;
                end
            end
            S_CSTORE: begin
                o_cmd.ang_store = 1'b1;
                case (r_sel)
                    q2e_pkg::SEL_PITCH: begin
                        n_sel   = q2e_pkg::SEL_YAW;
                        n_state = S_CINIT;
                    end
                    q2e_pkg::SEL_YAW: begin
                        n_sel   = q2e_pkg::SEL_ROLL;
                        n_state = S_CINIT;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_FIN: begin
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.fin = 1'b1;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sel    <= q2e_pkg::SEL_YAW;
            r_ovalid <= 1'b0;
            r_sat    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
            r_sat    <= n_sat;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    localparam longint LIMIT_CYCLES = 2000000;
    localparam longint ONE_Q28 = 64'sd1 << 28;
    localparam longint HALF_TURN = 64'sd180 * 65536;
    localparam longint QUARTER_TURN = 64'sd90 * 65536;
    localparam int ANGLE_MAX = 23040;
    localparam int FULL_TURN = 46080;
    localparam int STALL_CYCLES = 3000;
    localparam longint ARCTAN_DEG16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;  // quat_w, quat_x, quat_y, quat_z
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;  // yaw_deg, pitch_deg, roll_deg

    t_angles     expected_angles[$];
    logic signed [15:0] centre_offset[3];
    logic        centre_taken;
    int          errors;
    int          beats_in;
    int          beats_out;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          stall_request;
    int          stall_served;
    int          stall_left;
    longint      cycle_count;

    quaternion_to_euler_recentred u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint arctan2_deg16(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < q2e_pkg::COR_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_DEG16[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_DEG16[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int deg16_to_q7(longint z);
        longint q;
        q = (z + 256) >>> 9;
        if (q > ANGLE_MAX) begin
            q = ANGLE_MAX;
        end
        if (q < -ANGLE_MAX) begin
            q = -ANGLE_MAX;
        end
        return int'(q);
    endfunction

    function automatic logic signed [15:0] wrap_angle(int d);
        if (d < -ANGLE_MAX) begin
            d = d + FULL_TURN;
        end else if (d > ANGLE_MAX) begin
            d = d - FULL_TURN;
        end
        return d[15:0];
    endfunction

    task automatic predict_angles(input logic [63:0] quat);
        longint w;
        longint x;
        longint y;
        longint z;
        longint sin_roll;
        longint cos_roll;
        longint sin_pitch;
        longint sin_yaw;
        longint cos_yaw;
        longint pitch_z;
        longint unsigned mag;
        int     ang[3];
        t_angles res;
        w = longint'($signed(quat[15:0]));
        x = longint'($signed(quat[31:16]));
        y = longint'($signed(quat[47:32]));
        z = longint'($signed(quat[63:48]));
        sin_roll  = 2 * (w * x + y * z);
        cos_roll  = ONE_Q28 - 2 * (x * x + y * y);
        sin_pitch = 2 * (w * y - z * x);
        sin_yaw   = 2 * (w * z + x * y);
        cos_yaw   = ONE_Q28 - 2 * (y * y + z * z);
        if (sin_pitch >= ONE_Q28) begin
            pitch_z = QUARTER_TURN;
        end else if (sin_pitch <= -ONE_Q28) begin
            pitch_z = -QUARTER_TURN;
        end else begin
            mag = (sin_pitch < 0) ? -sin_pitch : sin_pitch;
            pitch_z = arctan2_deg16(sin_pitch,
                longint'(floor_sqrt((64'd1 << 56) - mag * mag)));
        end
        ang[0] = deg16_to_q7(arctan2_deg16(sin_yaw, cos_yaw));
        ang[1] = deg16_to_q7(pitch_z);
        ang[2] = deg16_to_q7(arctan2_deg16(sin_roll, cos_roll));
        if (!centre_taken) begin
            for (int k = 0; k < 3; k++) begin
                centre_offset[k] = ang[k][15:0];
            end
            centre_taken = 1'b1;
        end
        res.yaw   = wrap_angle(ang[0] - int'(centre_offset[0]));
        res.pitch = wrap_angle(ang[1] - int'(centre_offset[1]));
        res.roll  = wrap_angle(ang[2] - int'(centre_offset[2]));
        expected_angles.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("tb: mismatch on %s at beat %0d: got %0d, expected %0d",
                 what, beats_out, got, want);
    endtask

    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x, w};
        do @(posedge i_clk); while (!o_s_tready);
        predict_angles(i_s_tdata);
        beats_in++;
    endtask

    task automatic go_idle_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_angles.size() != 0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_request != stall_served) begin
            stall_served = stall_request;
            stall_left = STALL_CYCLES;
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (expected_angles.size() == 0) begin
                errors++;
                $display("tb: unexpected output beat %0d", beats_out);
            end else begin
                want = expected_angles.pop_front();
                if (got.yaw !== want.yaw) begin
                    report_mismatch("yaw", got.yaw, want.yaw);
                end
                if (got.pitch !== want.pitch) begin
                    report_mismatch("pitch", got.pitch, want.pitch);
                end
                if (got.roll !== want.roll) begin
                    report_mismatch("roll", got.roll, want.roll);
                end
            end
            beats_out++;
        end
    end

    task automatic test_directed();
        // The first beat sets the centring offsets, so it is a tilted pose.
        send_quat(16'sd14189, 16'sd4096, 16'sd4096, 16'sd5793);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_quat(16'sd0, 16'sd8192, 16'sd8192, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd8192, 16'sd8192);
        send_quat(16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
        send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
        send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd100, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(-16'sd100, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd200, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(-16'sd200, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(-16'sd14189, 16'sd4096, -16'sd4096, 16'sd5793);
        send_quat(16'sd3000, -16'sd12000, 16'sd9000, -16'sd7000);
        go_idle_until_drained();
    endtask

    task automatic test_random(input int count);
        logic [15:0] c[4];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(3) == 0) begin
                    c[k] = 16'($urandom);
                end else begin
                    c[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
                end
            end
            send_quat(c[0], c[1], c[2], c[3]);
        end
    endtask

    task automatic test_output_stall();
        stall_request = stall_request + 1;
        for (int n = 0; n < 6; n++) begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        go_idle_until_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        centre_taken = 1'b0;
        beats_in = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        stall_request = 0;
        for (int k = 0; k < 3; k++) begin
            centre_offset[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        sender_idle_pct = 20;
        receiver_idle_pct = 55;
        test_random(260);
        sender_idle_pct = 55;
        receiver_idle_pct = 20;
        test_random(260);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random(260);
        test_output_stall();

        go_idle_until_drained();
        repeat (200) @(posedge i_clk);
        $display("tb: %0d quaternions sent, %0d angle sets checked", beats_in, beats_out);
        $display("tb: covered centring, pitch limits, half-turn wrap, stalls on both sides");
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
